// ===== rtl/fermat_primality_check_top_assert.svh =====
// ----------------------------------------------------------------------------
// fermat primality check assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef FERMAT_PRIMALITY_CHECK_TOP_ASSERT_SVH
`define FERMAT_PRIMALITY_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define FPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  localparam int OPERAND_BITS_DEF = 31;

  // which modular multiplication runs in the shared unit
  typedef enum logic [1:0] {
    MSEL_REDUCE = 2'd0,  // base mod n, as base * 1
    MSEL_ACC    = 2'd1,  // acc * base mod n
    MSEL_SQR    = 2'd2   // base * base mod n
  } msel_t;

  typedef struct packed {
    logic  load;       // capture a new input word
    logic  mul_start;  // latch operands, clear partial product
    logic  mul_step;   // one multiplier bit
    msel_t msel;       // operand select for mul_start
    logic  wb_base;    // product into base register
    logic  wb_acc;     // product into accumulator
    logic  exp_shift;  // next exponent bit
  } fpc_cmd_t;

  typedef struct packed {
    logic n_le_one;  // candidate at most one
    logic exp_lsb;   // current exponent bit
    logic pass;      // candidate above one and residue equals one
  } fpc_status_t;

endpackage

`default_nettype wire

// ===== rtl/fpc_datapath.sv =====
// ----------------------------------------------------------------------------
// fpc_datapath
// operand registers and a bit-serial interleaved modular multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_datapath #(
  parameter int OPERAND_BITS = fpc_pkg::OPERAND_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic [OPERAND_BITS-1:0] in_candidate,
  input  wire logic [OPERAND_BITS-1:0] in_witness_base,
  input  wire fpc_pkg::fpc_cmd_t       cmd,
  output fpc_pkg::fpc_status_t         status
);

  localparam int W = OPERAND_BITS;

  logic [W-1:0] n_r;
  logic [W-1:0] exp_r;
  logic [W-1:0] base_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] prod_r;
  logic [W-1:0] x_r;
  logic [W-1:0] y_r;

  logic [W-1:0] x_sel;
  logic [W-1:0] y_sel;
  logic [W+1:0] t_sum;
  logic [W+1:0] n1;
  logic [W+1:0] n2;
  logic [W+1:0] t_red;

  // operand select
  always_comb begin
    case (cmd.msel)
      fpc_pkg::MSEL_REDUCE: begin
        x_sel = W'(1);
        y_sel = base_r;
      end
      fpc_pkg::MSEL_ACC: begin
        x_sel = base_r;
        y_sel = acc_r;
      end
      fpc_pkg::MSEL_SQR: begin
        x_sel = base_r;
        y_sel = base_r;
      end
      default: begin
        x_sel = base_r;
        y_sel = base_r;
      end
    endcase
  end

  // 2p + bit*x stays below 3n, so one of three candidates is the residue
  always_comb begin
    n1    = {2'b00, n_r};
    n2    = {1'b0, n_r, 1'b0};
    t_sum = {1'b0, prod_r, 1'b0} + (y_r[W-1] ? {2'b00, x_r} : '0);
    if (t_sum >= n2) begin
      t_red = t_sum - n2;
    end else if (t_sum >= n1) begin
      t_red = t_sum - n1;
    end else begin
      t_red = t_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= in_candidate;
      base_r <= in_witness_base;
      exp_r  <= in_candidate - W'(1);
      acc_r  <= W'(1);
    end
    if (cmd.mul_start) begin
      x_r    <= x_sel;
      y_r    <= y_sel;
      prod_r <= '0;
    end
    if (cmd.mul_step) begin
      prod_r <= t_red[W-1:0];
      y_r    <= {y_r[W-2:0], 1'b0};
    end
    if (cmd.wb_base) begin
      base_r <= prod_r;
    end
    if (cmd.wb_acc) begin
      acc_r <= prod_r;
    end
    if (cmd.exp_shift) begin
      exp_r <= exp_r >> 1;
    end
  end

  always_comb begin
    status.n_le_one = (n_r <= W'(1));
    status.exp_lsb  = exp_r[0];
    status.pass     = (n_r > W'(1)) && (acc_r == W'(1));
  end

endmodule

`default_nettype wire

// ===== rtl/fpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpc_ctrl
// sequencer for reduce, square-and-multiply and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_ctrl #(
  parameter int OPERAND_BITS = fpc_pkg::OPERAND_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_probable_prime,
  output fpc_pkg::fpc_cmd_t         cmd,
  input  wire fpc_pkg::fpc_status_t status
);

  `include "fermat_primality_check_top_assert.svh"

  localparam int CW = $clog2(OPERAND_BITS);
  localparam logic [CW-1:0] LAST = CW'(OPERAND_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NEXT,
    ST_MUL,
    ST_WB,
    ST_DONE
  } state_t;

  state_t            state_r,   state_nxt;
  fpc_pkg::msel_t    phase_r,   phase_nxt;
  logic [CW-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0]     exp_cnt_r, exp_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_pp_r,    out_pp_nxt;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    exp_cnt_nxt   = exp_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pp_nxt    = out_pp_r;
    cmd           = '0;
    cmd.msel      = phase_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.n_le_one) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.msel      = fpc_pkg::MSEL_REDUCE;
          phase_nxt     = fpc_pkg::MSEL_REDUCE;
          bit_cnt_nxt   = LAST;
          state_nxt     = ST_MUL;
        end
      end
      ST_NEXT: begin
        cmd.mul_start = 1'b1;
        bit_cnt_nxt   = LAST;
        state_nxt     = ST_MUL;
        if (status.exp_lsb) begin
          cmd.msel  = fpc_pkg::MSEL_ACC;
          phase_nxt = fpc_pkg::MSEL_ACC;
        end else begin
          cmd.msel  = fpc_pkg::MSEL_SQR;
          phase_nxt = fpc_pkg::MSEL_SQR;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        bit_cnt_nxt  = bit_cnt_r - CW'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        case (phase_r)
          fpc_pkg::MSEL_REDUCE: begin
            cmd.wb_base = 1'b1;
            exp_cnt_nxt = LAST;
            state_nxt   = ST_NEXT;
          end
          fpc_pkg::MSEL_ACC: begin
            // accumulate, then square the same base right away
            cmd.wb_acc    = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.msel      = fpc_pkg::MSEL_SQR;
            phase_nxt     = fpc_pkg::MSEL_SQR;
            bit_cnt_nxt   = LAST;
            state_nxt     = ST_MUL;
          end
          default: begin
            cmd.wb_base   = 1'b1;
            cmd.exp_shift = 1'b1;
            exp_cnt_nxt   = exp_cnt_r - CW'(1);
            if (exp_cnt_r == '0) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_NEXT;
            end
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pp_nxt    = status.pass;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= fpc_pkg::MSEL_REDUCE;
      bit_cnt_r   <= '0;
      exp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_pp_r <= out_pp_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_probable_prime = out_pp_r;

  `FPC_ASSERT_NEXT(a_accept_checks, in_valid && in_ready, state_r == ST_CHECK,
                   "accepted word did not move to candidate check")
  `FPC_ASSERT_NEXT(a_mul_ends, state_r == ST_MUL && bit_cnt_r == '0, state_r == ST_WB,
                   "multiplier did not finish after its last bit")
  `FPC_ASSERT_NEXT(a_result_posted,
                   state_r == ST_DONE && (!out_valid_r || out_ready),
                   out_valid_r && state_r == ST_IDLE,
                   "finished result was not posted to the output register")
  `FPC_ASSERT_NOW(a_busy_no_accept, state_r != ST_IDLE, !cmd.load,
                  "new word captured while a test is running")

endmodule

`default_nettype wire

// ===== rtl/fermat_primality_check_top.sv =====
// ----------------------------------------------------------------------------
// fermat_primality_check_top
// one fermat round: witness_base^(candidate-1) mod candidate == 1
// ----------------------------------------------------------------------------
// a candidate of zero or one goes straight to the result; otherwise the run time grows
//   with OPERAND_BITS and with the number of set bits of candidate-1
// the run time is set by the bit-serial modular multiplier, one multiplier bit a cycle
// throughput: one word at a time; the next word is taken as soon as the result is
//   in the output register, even while it waits to be taken
// reset: synchronous active-low rst_n clears the sequencer and the output valid
`default_nettype none

module fermat_primality_check_top #(
  parameter int OPERAND_BITS = fpc_pkg::OPERAND_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [OPERAND_BITS-1:0] in_candidate,
  input  wire logic [OPERAND_BITS-1:0] in_witness_base,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_probable_prime
);

  // command and status between sequencer and datapath
  fpc_pkg::fpc_cmd_t    cmd;
  fpc_pkg::fpc_status_t status;

  // datapath: holds n, n-1 exponent, base, accumulator and the
  // shift-add multiplier that reduces 2p + bit*x below n every cycle
  fpc_datapath #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_datapath (
    .clk             (clk),
    .in_candidate    (in_candidate),
    .in_witness_base (in_witness_base),
    .cmd             (cmd),
    .status          (status)
  );

  // sequencer: base reduction, then per exponent bit an optional
  // multiply into acc followed by a squaring of base
  fpc_ctrl #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_probable_prime (out_probable_prime),
    .cmd                (cmd),
    .status             (status)
  );

endmodule

`default_nettype wire

// ===== tb/sv/fermat_primality_check_checker.sv =====
// ----------------------------------------------------------------------------
// fermat primality check scoreboard
// watches both channels, predicts each verdict and compares results in order
// ----------------------------------------------------------------------------
module fermat_primality_check_checker #(
  parameter int W = fpc_pkg::OPERAND_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [W-1:0]    in_candidate,
  input  logic [W-1:0]    in_witness_base,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic            out_probable_prime,
  output int unsigned     words_in_flight,
  output int unsigned     fail_count
);

  typedef struct {
    logic [W-1:0] cand;
    logic [W-1:0] base;
    logic         verdict;
  } round_t;

  round_t      pending_rounds[$];
  round_t      oldest;
  int unsigned results_seen;

  // base^(cand-1) mod cand == 1, right-to-left square and multiply
  function automatic logic fermat_passes(logic [W-1:0] cand, logic [W-1:0] base);
    logic [63:0] n;
    logic [63:0] sq;
    logic [63:0] acc;
    logic [63:0] e;
    n = 64'(cand);
    if (n <= 64'd1) return 1'b0;
    sq  = 64'(base) % n;
    e   = n - 64'd1;
    acc = 64'd1;
    for (int k = 0; k < W; k++) begin
      if (e[k]) acc = (acc * sq) % n;
      sq = (sq * sq) % n;
    end
    return acc == 64'd1;
  endfunction

  initial begin
    words_in_flight = 0;
    fail_count      = 0;
    results_seen    = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      // retire first: a result never belongs to the word taken in the same cycle
      if (out_valid && out_ready) begin
        if (pending_rounds.size() == 0) begin
          if (fail_count < 10)
            $display("result %0d: unexpected word, probable_prime=%0b",
                     results_seen, out_probable_prime);
          fail_count++;
        end else begin
          oldest = pending_rounds.pop_front();
          if (out_probable_prime !== oldest.verdict) begin
            if (fail_count < 10)
              $display("result %0d: n=%0d b=%0d probable_prime expected %0b got %0b",
                       results_seen, oldest.cand, oldest.base, oldest.verdict,
                       out_probable_prime);
            fail_count++;
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready)
        pending_rounds.push_back('{in_candidate, in_witness_base,
                                   fermat_passes(in_candidate, in_witness_base)});
    end
    words_in_flight <= pending_rounds.size();
  end

endmodule

// ===== tb/sv/tb_fermat_primality_check_top.sv =====
// ----------------------------------------------------------------------------
// fermat primality check testbench
// drives candidate/base words through the block under several idle patterns,
// including a long output hold-off; the scoreboard checks every verdict
// ----------------------------------------------------------------------------
module tb_fermat_primality_check_top;

  localparam int W = fpc_pkg::OPERAND_BITS_DEF;

  // the drain is longer than the worst round, so it covers one full round
  localparam int unsigned DRAIN_CYCLES = 2500;
  // ~140 words at worst latency plus the hold-off, taken several times over
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  // long enough for one round in flight plus one parked result to back up the input
  localparam int unsigned LONG_HOLD    = 6000;
  localparam int unsigned PRESSURE_WORDS = 4;
  localparam int unsigned PHASE_WORDS  = 28;

  localparam logic [W-1:0] MAXV = '1;

  // directed words: extremes, tiny candidates, bases at or above the candidate,
  // zero base, multiples, pseudoprimes and carmichael numbers
  localparam int NDIR = 23;
  localparam logic [W-1:0] DIR_CAND [NDIR] = '{
    0, 0, 1, 1, 2, 2, 2, 3, 7, 7, 7, 15, 341, 561, 1105, 65537,
    MAXV, MAXV, MAXV, MAXV - 1, 31'h40000000, 31'h2AAAAAAA, 2147483629
  };
  localparam logic [W-1:0] DIR_BASE [NDIR] = '{
    5, 0, 1, MAXV, 1, 2, MAXV, 2, 100, 14, 0, 2, 2, 2, 3, 3,
    2, MAXV, MAXV - 1, 3, 31'h55555555, 31'h7FFFFFFE, 2147483628
  };

  // primes, so that many rounds come back positive
  localparam int NPRIME = 12;
  localparam logic [W-1:0] PRIMES [NPRIME] = '{
    2147483647, 2147483629, 2147483587, 2147483563, 1073741789, 1000000007,
    998244353, 536870909, 268435399, 65537, 7919, 104729
  };
  // composites that fool the test for most bases
  localparam int NCARM = 8;
  localparam logic [W-1:0] CARMICHAEL [NCARM] = '{
    561, 1105, 1729, 2465, 2821, 6601, 8911, 41041
  };

  // idle patterns per phase: none, sender idle, receiver stalls, both
  localparam int unsigned SENDER_IDLE [4] = '{0, 82, 0, 15};
  localparam int unsigned RECV_STALL  [4] = '{0, 0, 82, 15};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [W-1:0] in_candidate = '0;
  logic [W-1:0] in_witness_base = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic         out_probable_prime;

  int unsigned  words_in_flight;
  int unsigned  fail_count;

  int unsigned  sender_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  hold_requests = 0;
  int unsigned  cycle_count = 0;

  fermat_primality_check_top #(
    .OPERAND_BITS(W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_candidate      (in_candidate),
    .in_witness_base   (in_witness_base),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_probable_prime(out_probable_prime)
  );

  fermat_primality_check_checker #(
    .W(W)
  ) verdict_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_candidate      (in_candidate),
    .in_witness_base   (in_witness_base),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_probable_prime(out_probable_prime),
    .words_in_flight   (words_in_flight),
    .fail_count        (fail_count)
  );

  // free-running clock
  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_left = LONG_HOLD;
        hold_served++;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one word, hold it until taken, then maybe go idle for a while
  task automatic offer_word(input logic [W-1:0] cand, input logic [W-1:0] base);
    in_valid        <= 1'b1;
    in_candidate    <= cand;
    in_witness_base <= base;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // random word, weighted toward rounds that get through the whole exponent
  task automatic pick_word(output logic [W-1:0] cand, output logic [W-1:0] base);
    int unsigned kind;
    int unsigned mult;
    kind = $urandom_range(99);
    if (kind < 30) begin
      // prime with a legal witness: expect a pass
      cand = PRIMES[$urandom_range(NPRIME - 1)];
      base = W'($urandom_range(32'(cand) - 1, 1));
    end else if (kind < 40) begin
      cand = CARMICHAEL[$urandom_range(NCARM - 1)];
      base = W'($urandom_range(32'(cand) - 1, 1));
    end else if (kind < 55) begin
      cand = W'($urandom_range(400, 2));
      base = W'($urandom_range(32'(cand) - 1, 1));
    end else if (kind < 75) begin
      // full-range candidate, legal witness when there is one
      cand = W'($urandom);
      if (cand > 1) base = W'($urandom_range(32'(cand) - 1, 1));
      else base = W'($urandom);
    end else if (kind < 85) begin
      // base may sit at or above the candidate
      cand = W'($urandom);
      base = W'($urandom);
    end else if (kind < 90) begin
      cand = W'($urandom_range(1));
      base = W'($urandom);
    end else if (kind < 95) begin
      // zero base or a multiple of the candidate
      cand = W'($urandom_range(65535, 2));
      mult = $urandom_range(32767);
      base = W'(32'(cand) * mult);
    end else begin
      cand = 2;
      base = W'($urandom);
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [W-1:0] cand;
    logic [W-1:0] base;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NDIR; i++)
      offer_word(DIR_CAND[i], DIR_BASE[i]);

    // back-pressure: receiver holds off while the sender keeps offering
    hold_requests++;
    for (int i = 0; i < PRESSURE_WORDS; i++) begin
      pick_word(cand, base);
      offer_word(cand, base);
    end

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = SENDER_IDLE[p];
      stall_pct       = RECV_STALL[p];
      for (int i = 0; i < PHASE_WORDS; i++) begin
        pick_word(cand, base);
        offer_word(cand, base);
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (words_in_flight != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fpc_pkg.sv
rtl/fpc_datapath.sv
rtl/fpc_ctrl.sv
rtl/fermat_primality_check_top.sv
tb/sv/fermat_primality_check_checker.sv
tb/sv/tb_fermat_primality_check_top.sv
